/* rtl/assert_macros.svh */
// Assertion macros shared by the bitmap allocator modules.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define BBA_NEVER(label, cond, msg) \
    `BBA_ASSERT(label, !(cond), msg)

`endif

/* rtl/bba_pkg.sv */
// Package for the bitmap block allocator: field types, operation codes,
// controller/datapath command and status structs and the bit search helper.
package bba_pkg;

    // Field widths and limits.
    localparam int BITMAP_BYTES_DEF = 128;
    localparam int BYTE_W           = 8;
    localparam int BLOCK_W          = 10;
    localparam int MODE_W           = 2;
    localparam int MAX_BLOCKS       = 1 << BLOCK_W;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [BYTE_W-1:0]  t_byte;

    // Operation codes carried on the mode field.
    localparam t_mode MODE_FIND = 2'd0;
    localparam t_mode MODE_SET  = 2'd1;
    localparam t_mode MODE_CLR  = 2'd2;

    // How the pending result is updated.
    typedef logic [1:0] t_res_sel;
    localparam t_res_sel RES_ECHO_OK = 2'd0;
    localparam t_res_sel RES_HIT     = 2'd1;
    localparam t_res_sel RES_MISS    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     rd_item;
        logic     rd_scan;
        logic     wr_item;
        logic     set_res;
        t_res_sel res_sel;
        logic     push;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_find;
        logic in_mark_ok;
        logic hit;
        logic scan_last;
        logic out_free;
    } t_status;

    // Position of the lowest clear bit of a byte (zero when none is clear).
    function automatic logic [2:0] lowest_zero(input t_byte b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            if (!b[k]) begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

endpackage

/* rtl/bba_datapath.sv */
// Datapath of the bitmap block allocator: bitmap memory with valid bits,
// scan counter, item and result registers. Depends on bba_pkg, assert_macros.svh.
`include "assert_macros.svh"

module bba_datapath #(
    parameter int BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bba_pkg::t_mode    i_mode,
    input  bba_pkg::t_block   i_block_number,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_found,
    output bba_pkg::t_block   o_free_block,
    input  bba_pkg::t_cmd     i_cmd,
    output bba_pkg::t_status  o_status
);

    // Only the bytes that a 10-bit block number can reach are stored.
    localparam int TOTAL_BLOCKS = BITMAP_BYTES * bba_pkg::BYTE_W;
    localparam int MEM_DEPTH    = (TOTAL_BLOCKS > bba_pkg::MAX_BLOCKS)
                                  ? bba_pkg::MAX_BLOCKS / bba_pkg::BYTE_W : BITMAP_BYTES;
    localparam int AW           = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int LAST         = MEM_DEPTH - 1;

    // Bitmap storage; an entry whose valid bit is clear reads as all free.
    bba_pkg::t_byte        r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  r_valid;

    // Item and scan registers.
    bba_pkg::t_mode        r_mode;
    bba_pkg::t_block       r_blk;
    logic [AW-1:0]         r_scan_addr;

    // Registered read port.
    bba_pkg::t_byte        r_rd_byte;
    logic                  r_rd_ok;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_rd_live;

    // Pending result and output word.
    logic                  r_res_found;
    bba_pkg::t_block       r_res_block;
    logic                  r_o_valid;
    logic                  r_o_found;
    bba_pkg::t_block       r_o_block;

    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_idx;
    logic                  rd_en;
    bba_pkg::t_byte        rd_eff;
    bba_pkg::t_byte        bit_mask;
    bba_pkg::t_byte        wr_byte;
    bba_pkg::t_block       hit_block;
    logic                  hit;

    // Address selection and read-modify-write data.
    always_comb begin
        wr_idx    = r_blk[3 +: AW];
        rd_addr   = i_cmd.rd_item ? wr_idx : r_scan_addr;
        rd_en     = i_cmd.rd_item | i_cmd.rd_scan;
        rd_eff    = r_rd_ok ? r_rd_byte : '0;
        bit_mask  = bba_pkg::t_byte'(1) << r_blk[2:0];
        wr_byte   = (r_mode == bba_pkg::MODE_SET) ? (rd_eff | bit_mask) : (rd_eff & ~bit_mask);
        hit       = r_rd_live && (rd_eff != '1);
        hit_block = bba_pkg::t_block'({r_rd_idx, bba_pkg::lowest_zero(rd_eff)});
    end

    // Status toward the controller.
    always_comb begin
        o_status.in_find    = (i_mode == bba_pkg::MODE_FIND);
        o_status.in_mark_ok = ((i_mode == bba_pkg::MODE_SET) || (i_mode == bba_pkg::MODE_CLR))
                              && (32'(i_block_number) < TOTAL_BLOCKS);
        o_status.hit        = hit;
        o_status.scan_last  = (r_scan_addr == AW'(LAST));
        o_status.out_free   = !r_o_valid || i_ready;
    end

    // Memory array: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_item) begin
            r_mem[wr_idx] <= wr_byte;
        end
        if (rd_en) begin
            r_rd_byte <= r_mem[rd_addr];
        end
    end

    // Valid bits and read tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_live <= 1'b0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_cmd.wr_item) begin
                r_valid[wr_idx] <= 1'b1;
            end
            r_rd_live <= rd_en;
            if (rd_en) begin
                r_rd_ok <= r_valid[rd_addr];
            end
        end
    end

    // Read index, item capture and scan counter.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_idx <= rd_addr;
        end
        if (i_cmd.load) begin
            r_mode      <= i_mode;
            r_blk       <= i_block_number;
            r_scan_addr <= '0;
        end else if (i_cmd.rd_scan && (r_scan_addr != AW'(LAST))) begin
            r_scan_addr <= r_scan_addr + AW'(1);
        end
    end

    // Pending result: starts as a failed echo and is refined by the operation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_found <= 1'b0;
            r_res_block <= i_block_number;
        end else if (i_cmd.set_res) begin
            unique case (i_cmd.res_sel)
                bba_pkg::RES_ECHO_OK: begin
                    r_res_found <= 1'b1;
                end
                bba_pkg::RES_HIT: begin
                    r_res_found <= 1'b1;
                    r_res_block <= hit_block;
                end
                bba_pkg::RES_MISS: begin
                    r_res_found <= 1'b0;
                    r_res_block <= '0;
                end
                default: begin
                    r_res_found <= r_res_found;
                end
            endcase
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_found <= r_res_found;
            r_o_block <= r_res_block;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_found      = r_o_found;
    assign o_free_block = r_o_block;

    // A write leaves its entry valid, so it is never again read back as all free.
    `BBA_ASSERT(a_wr_sets_valid, i_cmd.wr_item |=> r_valid[$past(wr_idx)],
        "bitmap write did not set the entry valid")
    // A new result word never overwrites one that has not been taken.
    `BBA_ASSERT(a_push_free, i_cmd.push |-> (!r_o_valid || i_ready),
        "result pushed over a pending word")
    // A reported hit comes from a live read with a clear bit.
    `BBA_ASSERT(a_hit_live,
        (i_cmd.set_res && (i_cmd.res_sel == bba_pkg::RES_HIT)) |-> hit,
        "hit recorded without a free bit in the read byte")

endmodule

/* rtl/bba_ctrl.sv */
// Controller of the bitmap block allocator: sequences accept, read-modify-write,
// scan and result delivery. Depends on bba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bba_pkg::t_status  i_status,
    output bba_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_RMW_RD    = 3'd1;
    localparam logic [2:0] ST_RMW_WR    = 3'd2;
    localparam logic [2:0] ST_SCAN      = 3'd3;
    localparam logic [2:0] ST_SCAN_TAIL = 3'd4;
    localparam logic [2:0] ST_RESULT    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    priority if (i_status.in_find) begin
                        n_state = ST_SCAN;
                    end else if (i_status.in_mark_ok) begin
                        n_state = ST_RMW_RD;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_RMW_RD: begin
                o_cmd.rd_item = 1'b1;
                n_state       = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                o_cmd.wr_item = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res_sel = bba_pkg::RES_ECHO_OK;
                n_state       = ST_RESULT;
            end
            ST_SCAN: begin
                // One byte read per cycle; the previous byte is checked meanwhile.
                o_cmd.rd_scan = 1'b1;
                if (i_status.hit) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = bba_pkg::RES_HIT;
                    n_state       = ST_RESULT;
                end else if (i_status.scan_last) begin
                    n_state = ST_SCAN_TAIL;
                end
            end
            ST_SCAN_TAIL: begin
                o_cmd.set_res = 1'b1;
                o_cmd.res_sel = i_status.hit ? bba_pkg::RES_HIT : bba_pkg::RES_MISS;
                n_state       = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // At most one memory access is requested in a cycle.
    `BBA_ASSERT(a_one_access, $onehot0({o_cmd.rd_item, o_cmd.rd_scan, o_cmd.wr_item}),
        "more than one memory access in a cycle")
    // The write of a mark always follows its read.
    `BBA_ASSERT(a_rmw_order, (r_state == ST_RMW_WR) |-> ($past(r_state) == ST_RMW_RD),
        "bitmap write without a preceding read")
    // Delivering a result returns the controller to idle.
    `BBA_ASSERT(a_push_idle, o_cmd.push |=> (r_state == ST_IDLE),
        "controller not idle after delivering a result")

endmodule

/* rtl/bitmap_block_allocator_top.sv */
// Top level of the bitmap block allocator: joins controller and datapath.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
// Keeps a used/free bit for each storage block (block n is bit n mod 8 of byte
// n/8) and handles one word at a time: mode 0 reports the lowest free block
// without claiming it, mode 1 marks a block used, mode 2 marks it free; mode 3
// and a mark beyond the bitmap echo the block number with found clear. A mark
// reads its byte and writes it back before the result register is loaded; a
// find scans at most min(BITMAP_BYTES, 128) bytes, reading the bitmap memory
// one byte per cycle and stopping at the first byte with a clear bit. The
// bitmap reads as all free after reset through per-byte valid bits, so no
// clearing pass is needed. A finished result waits in the output register;
// the next word is accepted once the result has moved there.
module bitmap_block_allocator_top #(
    parameter int BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bba_pkg::t_mode   i_mode,
    input  bba_pkg::t_block  i_block_number,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_found,
    output bba_pkg::t_block  o_free_block
);

    bba_pkg::t_cmd    cmd;
    bba_pkg::t_status status;

    // Sequencer.
    bba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Bitmap memory and result path.
    bba_datapath #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_mode),
        .i_block_number (i_block_number),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_free_block   (o_free_block),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule

/* sim/bitmap_alloc_checker.sv */
`timescale 1ns / 100ps
// Checker for the bitmap block allocator: keeps its own copy of the used/free bitmap,
// predicts the answer to every accepted word and compares the results in order.
// Depends on bba_pkg for the field types and the operation codes.
module bitmap_alloc_checker #(
    parameter int BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_word_valid,
    input  logic             i_word_ready,
    input  bba_pkg::t_mode   i_mode,
    input  bba_pkg::t_block  i_block_number,
    input  logic             i_result_valid,
    input  logic             i_result_ready,
    input  logic             i_found,
    input  bba_pkg::t_block  i_free_block,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked,
    output int               o_full_misses
);

    localparam int BLOCKS     = BITMAP_BYTES * bba_pkg::BYTE_W;
    localparam int SCAN_LIMIT = (BLOCKS < bba_pkg::MAX_BLOCKS) ? BLOCKS : bba_pkg::MAX_BLOCKS;

    typedef struct {
        logic            is_find;
        logic            found;
        bba_pkg::t_block block;
    } t_answer;

    // One bit per block, 1 meaning used.
    logic    used_map [BLOCKS];
    t_answer answer_q [$];
    t_answer want;
    int      mismatches = 0;
    int      checked    = 0;
    int      misses     = 0;

    // Applies one word to the bitmap copy and returns the answer it should produce.
    function automatic t_answer allocate_answer(input bba_pkg::t_mode m,
                                                input bba_pkg::t_block b);
        t_answer a;
        a.is_find = (m == bba_pkg::MODE_FIND);
        a.found   = 1'b0;
        a.block   = b;
        case (m)
            bba_pkg::MODE_FIND: begin
                a.block = '0;
                for (int n = 0; n < SCAN_LIMIT && !a.found; n++) begin
                    if (!used_map[n]) begin
                        a.found = 1'b1;
                        a.block = bba_pkg::t_block'(n);
                    end
                end
            end
            bba_pkg::MODE_SET, bba_pkg::MODE_CLR: begin
                if (int'(b) < BLOCKS) begin
                    used_map[b] = (m == bba_pkg::MODE_SET);
                    a.found     = 1'b1;
                end
            end
            default: begin
                // The spare mode changes nothing and echoes the block number.
            end
        endcase
        return a;
    endfunction

    // Predict on every accepted word, compare on every accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (used_map[k]) used_map[k] = 1'b0;
            answer_q.delete();
        end else begin
            if (i_word_valid && i_word_ready) begin
                answer_q.push_back(allocate_answer(i_mode, i_block_number));
            end
            if (i_result_valid && i_result_ready) begin
                if (answer_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no word outstanding: found=%0b block=%0d",
                             $time, i_found, i_free_block);
                end else begin
                    want = answer_q.pop_front();
                    checked++;
                    if (want.is_find && !want.found) begin
                        misses++;
                    end
                    if (i_found !== want.found) begin
                        mismatches++;
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, i_found);
                    end
                    if (i_free_block !== want.block) begin
                        mismatches++;
                        $display("%0t: free_block mismatch: expected %0d, actual %0d",
                                 $time, want.block, i_free_block);
                    end
                end
            end
        end
        o_pending     <= answer_q.size();
        o_errors      <= mismatches;
        o_checked     <= checked;
        o_full_misses <= misses;
    end

endmodule

/* sim/bitmap_block_allocator_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the bitmap block allocator: drives words and result stalls,
// and gives the verdict. Depends on bba_pkg, the allocator RTL and bitmap_alloc_checker.
module bitmap_block_allocator_top_tb;

    localparam bba_pkg::t_mode MODE_SPARE  = 2'd3;
    localparam int             CYCLE_LIMIT = 2000000;
    localparam int             SETTLE      = 140;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_valid        = 1'b0;
    logic             o_ready;
    bba_pkg::t_mode   i_mode         = bba_pkg::MODE_FIND;
    bba_pkg::t_block  i_block_number = '0;
    logic             o_valid;
    logic             i_ready        = 1'b0;
    logic             o_found;
    bba_pkg::t_block  o_free_block;

    int      errors;
    int      pending;
    int      checked;
    int      full_misses;
    int      cycle_count    = 0;
    int      finds_sent     = 0;
    int      marks_sent     = 0;
    int      spares_sent    = 0;
    // While set, neither side idles.
    bit      calm           = 1'b0;

    bitmap_block_allocator_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_block_number (i_block_number),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_free_block   (o_free_block)
    );

    bitmap_alloc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word_valid   (i_valid),
        .i_word_ready   (o_ready),
        .i_mode         (i_mode),
        .i_block_number (i_block_number),
        .i_result_valid (o_valid),
        .i_result_ready (i_ready),
        .i_found        (o_found),
        .i_free_block   (o_free_block),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_misses  (full_misses)
    );

    always #4 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("bitmap_block_allocator_top test failed");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_pause();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side stalls on its own schedule.
    initial begin : drive_ready
        int hold;
        int open;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            hold = pick_pause();
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            open = calm ? 200 : $urandom_range(1, 8);
            repeat (open) @(posedge i_clk);
        end
    end

    // Offers one word, holds it until accepted, then idles for a random gap.
    task automatic put(input bba_pkg::t_mode m, input bba_pkg::t_block b);
        int gap;
        i_valid        <= 1'b1;
        i_mode         <= m;
        i_block_number <= b;
        do @(posedge i_clk); while (!o_ready);
        case (m)
            bba_pkg::MODE_FIND:                   finds_sent++;
            bba_pkg::MODE_SET, bba_pkg::MODE_CLR: marks_sent++;
            default:                              spares_sent++;
        endcase
        gap = pick_pause();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops sending until every outstanding result has been taken.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int              base;
        int              r;
        bba_pkg::t_block b;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: empty bitmap, edges of the block range, spare mode.
        put(bba_pkg::MODE_FIND, 10'h3FF);
        put(bba_pkg::MODE_SET, 10'd0);
        put(bba_pkg::MODE_FIND, 10'd0);
        put(bba_pkg::MODE_SET, 10'h3FF);
        put(bba_pkg::MODE_CLR, 10'h3FF);
        put(bba_pkg::MODE_SET, 10'd1);
        put(bba_pkg::MODE_SET, 10'd2);
        put(bba_pkg::MODE_FIND, 10'h2AA);
        put(bba_pkg::MODE_CLR, 10'd0);
        put(bba_pkg::MODE_FIND, 10'h155);
        put(MODE_SPARE, 10'h3FF);
        put(MODE_SPARE, 10'h2AA);
        put(bba_pkg::MODE_SET, 10'h155);
        put(bba_pkg::MODE_SET, 10'h2AA);
        put(bba_pkg::MODE_CLR, 10'h155);
        put(bba_pkg::MODE_CLR, 10'h2AA);
        put(bba_pkg::MODE_CLR, 10'd1);
        put(bba_pkg::MODE_SET, 10'd7);
        put(bba_pkg::MODE_SET, 10'd8);
        put(bba_pkg::MODE_FIND, 10'd0);
        drain();

        // Fill the whole bitmap in order, with finds along the way, until none is free.
        for (int n = 0; n < bba_pkg::MAX_BLOCKS; n++) begin
            put(bba_pkg::MODE_SET, bba_pkg::t_block'(n));
            if (n % 128 == 127) begin
                put(bba_pkg::MODE_FIND, bba_pkg::t_block'($urandom));
            end
        end
        put(bba_pkg::MODE_FIND, 10'd0);
        put(MODE_SPARE, 10'd5);
        put(bba_pkg::MODE_CLR, 10'h3FF);
        put(bba_pkg::MODE_FIND, 10'd0);
        put(bba_pkg::MODE_CLR, 10'd512);
        put(bba_pkg::MODE_FIND, 10'h3FF);
        drain();

        // Random words: sets lean below a moving boundary and clears above it, so
        // the lowest free block wanders over the whole range.
        for (int round = 0; round < 4; round++) begin
            base = $urandom_range(0, bba_pkg::MAX_BLOCKS - 1);
            calm = (round % 4 == 3);
            for (int k = 0; k < 30; k++) begin
                r = $urandom_range(0, 99);
                b = bba_pkg::t_block'($urandom);
                if (r < 30) begin
                    put(bba_pkg::MODE_FIND, b);
                end else if (r < 65) begin
                    if ($urandom_range(0, 9) < 7) b = bba_pkg::t_block'($urandom_range(0, base));
                    put(bba_pkg::MODE_SET, b);
                end else if (r < 95) begin
                    if ($urandom_range(0, 9) < 7) begin
                        b = bba_pkg::t_block'($urandom_range(base, bba_pkg::MAX_BLOCKS - 1));
                    end
                    put(bba_pkg::MODE_CLR, b);
                end else begin
                    put(MODE_SPARE, b);
                end
            end
            if (round == 1) begin
                drain();
            end
        end
        calm = 1'b0;

        // Let everything come out, then allow for the longest scan.
        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d finds, %0d marks and %0d spare-mode words; %0d results checked,",
                 finds_sent, marks_sent, spares_sent, checked);
        $display("%0d of them finds with every block in use.", full_misses);
        if (pending != 0) begin
            $display("%0d expected results never arrived.", pending);
        end
        if (errors == 0 && pending == 0) begin
            $display("bitmap_block_allocator_top test passed");
        end else begin
            $display("bitmap_block_allocator_top test failed");
        end
        $finish;
    end

endmodule
